@@ sv/i2c_bitbang_master_defines.svh @@
// assertion macros for the i2c bit-bang master checker
// no dependencies; users provide clk and arst_n in scope
`ifndef I2C_BITBANG_MASTER_DEFINES_SVH
`define I2C_BITBANG_MASTER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define I2CBB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/i2cbb_pkg.sv @@
// shared types and constants for the i2c bit-bang master
// no dependencies
`default_nettype none

package i2cbb_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_W = $clog2(BITS_PER_BYTE);

	localparam logic [15:0] HALF_PERIOD_RST = 16'd250;

	// command codes
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] write_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
	} res_t;

endpackage

`default_nettype wire

@@ sv/i2cbb_in_stage.sv @@
// input beat register of the i2c bit-bang master
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_in_stage import i2cbb_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_stall,
	input  item_t item,
	input  wire   adv,
	output logic  vld_s1,
	output item_t item_s1
);

	logic take;

	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

@@ sv/i2cbb_seq.sv @@
// pin sequencer: one tick of the start/stop/write/read state machine per beat
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_seq import i2cbb_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         step,
	input  item_t       item_s1,
	input  wire  [15:0] half_period,
	output res_t        res
);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_START_A = 11'b000_0000_0010,
		ST_START_B = 11'b000_0000_0100,
		ST_STOP_A  = 11'b000_0000_1000,
		ST_STOP_B  = 11'b000_0001_0000,
		ST_WR_A    = 11'b000_0010_0000,
		ST_WR_H    = 11'b000_0100_0000,
		ST_WR_L    = 11'b000_1000_0000,
		ST_RD_A    = 11'b001_0000_0000,
		ST_RD_L    = 11'b010_0000_0000,
		ST_RD_H    = 11'b100_0000_0000
	} state_t;

	state_t             st_q, st_d;
	logic [15:0]        pc_q, pc_d;
	logic [BIT_W-1:0]   bi_q, bi_d, bi_dec;
	logic [7:0]         sh_q, sh_d;
	logic [7:0]         rd_q, rd_d;
	logic               scl_q, scl_d;
	logic               dat_q, dat_d;
	logic               en_q, en_d;
	logic               done;
	logic [15:0]        hp_eff;

	assign hp_eff = (half_period == 16'd0) ? 16'd1 : half_period;
	assign bi_dec = bi_q - BIT_W'(1);

	always_comb begin
		st_d  = st_q;
		pc_d  = pc_q;
		bi_d  = bi_q;
		sh_d  = sh_q;
		rd_d  = rd_q;
		scl_d = scl_q;
		dat_d = dat_q;
		en_d  = en_q;
		done  = 1'b0;
		if (st_q == ST_IDLE) begin
			case (item_s1.action)
				ACT_START: begin
					st_d  = ST_START_A;
					pc_d  = 16'd1;
					en_d  = 1'b1;
					dat_d = 1'b1;
					scl_d = 1'b1;
				end
				ACT_STOP: begin
					st_d  = ST_STOP_A;
					pc_d  = 16'd1;
					en_d  = 1'b1;
					dat_d = 1'b0;
					scl_d = 1'b0;
				end
				ACT_WRITE: begin
					st_d  = ST_WR_A;
					pc_d  = 16'd1;
					sh_d  = item_s1.write_byte;
					bi_d  = BIT_W'(BITS_PER_BYTE - 1);
					en_d  = 1'b1;
					scl_d = 1'b0;
				end
				ACT_READ: begin
					st_d  = ST_RD_A;
					pc_d  = 16'd1;
					sh_d  = 8'd0;
					bi_d  = BIT_W'(BITS_PER_BYTE - 1);
					en_d  = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (pc_q < hp_eff) begin
			pc_d = pc_q + 16'd1;
		end else begin
			pc_d = 16'd1;
			case (st_q)
				ST_START_A: begin
					st_d  = ST_START_B;
					dat_d = 1'b0;
				end
				ST_START_B: begin
					scl_d = 1'b0;
					done  = 1'b1;
				end
				ST_STOP_A: begin
					st_d  = ST_STOP_B;
					scl_d = 1'b1;
				end
				ST_STOP_B: begin
					dat_d = 1'b1;
					done  = 1'b1;
				end
				ST_WR_A: begin
					st_d  = ST_WR_H;
					dat_d = sh_q[bi_q];
					scl_d = 1'b1;
				end
				ST_WR_H: begin
					st_d  = ST_WR_L;
					scl_d = 1'b0;
				end
				ST_WR_L: begin
					if (bi_q == '0) begin
						done = 1'b1;
					end else begin
						bi_d  = bi_dec;
						st_d  = ST_WR_H;
						dat_d = sh_q[bi_dec];
						scl_d = 1'b1;
					end
				end
				ST_RD_A: begin
					st_d  = ST_RD_L;
					scl_d = 1'b0;
				end
				ST_RD_L: begin
					st_d  = ST_RD_H;
					scl_d = 1'b1;
					if (item_s1.sda_in) begin
						sh_d[bi_q] = 1'b1;
					end
				end
				ST_RD_H: begin
					if (bi_q == '0) begin
						rd_d = sh_q;
						done = 1'b1;
					end else begin
						bi_d  = bi_dec;
						st_d  = ST_RD_L;
						scl_d = 1'b0;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				st_d = ST_IDLE;
				pc_d = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			pc_q  <= 16'd0;
			bi_q  <= '0;
			sh_q  <= 8'd0;
			rd_q  <= 8'd0;
			scl_q <= 1'b1;
			dat_q <= 1'b1;
			en_q  <= 1'b1;
		end else if (step) begin
			st_q  <= st_d;
			pc_q  <= pc_d;
			bi_q  <= bi_d;
			sh_q  <= sh_d;
			rd_q  <= rd_d;
			scl_q <= scl_d;
			dat_q <= dat_d;
			en_q  <= en_d;
		end
	end

	assign res.scl       = scl_d;
	assign res.sda_out   = en_d & dat_d;
	assign res.sda_drive = en_d;
	assign res.busy_res  = (st_d != ST_IDLE);
	assign res.done_res  = done;
	assign res.read_byte = rd_d;

endmodule

`default_nettype wire

@@ sv/i2cbb_out_stage.sv @@
// result beat register of the i2c bit-bang master
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_out_stage import i2cbb_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  vld_s1,
	input  res_t res,
	output logic adv,
	output logic out_valid,
	input  wire  out_stall,
	output res_t res_q
);

	assign adv = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ sv/i2c_bitbang_master.sv @@
// top level of the i2c bit-bang master: input register, sequencer, result register
// depends on i2cbb_pkg, i2cbb_in_stage, i2cbb_seq, i2cbb_out_stage
//
// each input beat is one tick of a pin-level i2c master. while idle, the tick's action
// starts a command: start (sda falls with scl high, then scl falls), stop (sda and scl low,
// scl rises, then sda rises), write byte (eight bits msb first, one scl pulse each) or
// read byte (sda released, eight bits sampled msb first on each scl rise). every phase
// holds for half_period ticks (zero counts as one); actions arriving while a command runs
// are ignored. each input beat yields exactly one result beat with the pin levels, busy,
// a done pulse and the last byte read. the block takes one beat per clock cycle while the
// result side is not stalled; a taken beat moves from the input register through the
// combinational sequencer outputs into the result register and shows on the result port.
// ack bits, clock stretching and arbitration are not handled. half_period is written
// through the cfg port, which is always ready, and should only change while no command
// runs.
`default_nettype none

module i2c_bitbang_master import i2cbb_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	// input beat channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  action,
	input  wire  [7:0]  write_byte,
	input  wire         sda_in,
	// result beat channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_byte,
	// half_period register write
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data
);

	item_t       item, item_s1;
	res_t        res, res_q;
	logic        vld_s1;
	logic        adv;
	logic [15:0] half_period_q;

	// config register, never back-pressured
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
		end
	end

	assign item.action     = action;
	assign item.write_byte = write_byte;
	assign item.sda_in     = sda_in;

	// input register: holds one beat while the result side is stalled
	i2cbb_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.adv      (adv),
		.vld_s1   (vld_s1),
		.item_s1  (item_s1)
	);

	// sequencer state advances only when the beat moves into the result register
	i2cbb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (vld_s1 && adv),
		.item_s1     (item_s1),
		.half_period (half_period_q),
		.res         (res)
	);

	// result register
	i2cbb_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign scl       = res_q.scl;
	assign sda_out   = res_q.sda_out;
	assign sda_drive = res_q.sda_drive;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign read_byte = res_q.read_byte;

endmodule

`default_nettype wire

@@ sv/i2cbb_chk.sv @@
// port-level checker for the i2c bit-bang master, bound to the top level
// depends on i2c_bitbang_master_defines.svh and i2c_bitbang_master
`default_nettype none
`include "i2c_bitbang_master_defines.svh"

module i2cbb_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        scl,
	input wire        sda_out,
	input wire        sda_drive,
	input wire        busy_res,
	input wire        done_res,
	input wire [7:0]  read_byte
);

	// a stalled result beat stays put
	`I2CBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(scl) && $stable(sda_out) && $stable(sda_drive) && $stable(busy_res) && $stable(done_res) && $stable(read_byte), "result beat changed while stalled")
	// with an empty result register the input side never stalls
	`I2CBB_ASSERT(a_no_stall_empty, !out_valid |-> !in_stall, "input stalled with empty result register")
	// the finishing tick reports idle
	`I2CBB_ASSERT(a_done_idle, (out_valid && done_res) |-> !busy_res, "done beat still busy")
	// a released data line carries no driven level
	`I2CBB_ASSERT(a_release_low, (out_valid && !sda_drive) |-> !sda_out, "sda_out high while released")

endmodule

bind i2c_bitbang_master i2cbb_chk u_chk (.*);

`default_nettype wire
